@@ rtl/ecpc_pkg.sv @@
// Package for the effect chain panel controller.
// Holds the request and result structs, the internal status structs and fixed constants.
// No dependencies.
package ecpc_pkg;

  localparam int unsigned NUM_POS = 4;
  localparam logic [3:0]  MAX_PARAM = 4'd9;
  localparam logic [15:0] LOCKOUT_RESET = 16'd7000;
  localparam logic [15:0] COUNT_MAX = 16'hFFFF;

  typedef struct packed {
    logic chain_button_level;
    logic effect_button_level;
    logic param_button_level;
    logic bypass_button_level;
  } in_t;

  typedef struct packed {
    logic [15:0] display_port;
    logic        bypass_on;
    logic [1:0]  effect_pos0;
    logic [1:0]  effect_pos1;
    logic [1:0]  effect_pos2;
    logic [1:0]  effect_pos3;
    logic [3:0]  param_pos0;
    logic [3:0]  param_pos1;
    logic [3:0]  param_pos2;
    logic [3:0]  param_pos3;
  } out_t;

  // What the display encoder needs to pick a character.
  typedef struct packed {
    logic       bypass;
    logic       show_param;
    logic [3:0] param;
    logic [1:0] position;
    logic [1:0] effect;
  } disp_sel_t;

  // Flag and table contents after one tick.
  typedef struct packed {
    logic                      bypass_on;
    logic [NUM_POS-1:0][1:0]   effect_tab;
    logic [NUM_POS-1:0][3:0]   param_tab;
  } tables_t;

endpackage

@@ rtl/ecpc_glyph.sv @@
// Seven-segment encoder for the effect chain panel controller.
// Picks the character for the current tick and remaps it onto the port word.
// Depends on ecpc_pkg.
module ecpc_glyph
  import ecpc_pkg::*;
(
  input  disp_sel_t   disp,
  output logic [15:0] port_word
);

  localparam logic [6:0] DASH_GLYPH = 7'h40;

  localparam logic [9:0][6:0] DIGIT_GLYPH = {
    7'h6F, 7'h7F, 7'h07, 7'h7D, 7'h6D, 7'h66, 7'h4F, 7'h5B, 7'h06, 7'h3F
  };

  // Indexed by {position, effect}.
  localparam logic [15:0][6:0] EFFECT_GLYPH = {
    7'h50, 7'h79, 7'h5E, 7'h4F,
    7'h78, 7'h71, 7'h39, 7'h5B,
    7'h76, 7'h7C, 7'h38, 7'h06,
    7'h39, 7'h6D, 7'h76, 7'h3F
  };

  logic [6:0] glyph;
  logic [3:0] digit;
  logic [6:0] seg;

  always_comb begin
    digit = (disp.param > 4'd9) ? 4'd9 : disp.param;
    if (disp.bypass) begin
      glyph = DASH_GLYPH;
    end else if (disp.show_param) begin
      glyph = DIGIT_GLYPH[digit];
    end else begin
      glyph = EFFECT_GLYPH[{disp.position, disp.effect}];
    end
  end

  // The board wires segments a..e to port bits in a shuffled order.
  assign seg = {glyph[6], glyph[5], glyph[0], glyph[1], glyph[4], glyph[3], glyph[2]};
  assign port_word = ~{4'b0000, seg, 5'b00000};

endmodule

@@ rtl/ecpc_core.sv @@
// Panel state and per-tick update for the effect chain panel controller.
// Holds lockout counter, position, effect, parameter, flags and the two tables.
// Depends on ecpc_pkg.
module ecpc_core
  import ecpc_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        advance,
  input  in_t         item,
  input  logic [15:0] lockout_ticks,
  output disp_sel_t   disp,
  output tables_t     tables
);

  logic [15:0] lockout_count, lockout_count_next;
  logic [1:0]  position, position_next;
  logic [1:0]  effect_sel, effect_sel_next;
  logic [3:0]  param_val, param_val_next;
  logic        bypass_flag, bypass_flag_next;
  logic        show_param_flag, show_param_flag_next;
  logic [NUM_POS-1:0][1:0] effect_table, effect_table_next;
  logic [NUM_POS-1:0][3:0] param_table, param_table_next;

  logic        locked_now, locked_after;
  logic        chain_acc, effect_acc, param_acc, bypass_acc, any_acc;
  logic [1:0]  eff_a;
  logic [3:0]  par_a, par_b;
  logic        show_a;
  logic [15:0] count_a;

  always_comb begin
    locked_now   = lockout_count < lockout_ticks;
    // Once a press restarts the counter, later buttons see a count of zero.
    locked_after = lockout_ticks != 16'd0;

    chain_acc = !item.chain_button_level && !locked_now && !bypass_flag;
    position_next = chain_acc ? position + 2'd1 : position;
    eff_a = chain_acc ? 2'd0 : effect_sel;
    par_a = chain_acc ? 4'd0 : param_val;

    effect_acc = !item.effect_button_level && !bypass_flag &&
                 !(chain_acc ? locked_after : locked_now);
    effect_sel_next = effect_acc ? eff_a + 2'd1 : eff_a;
    par_b = effect_acc ? 4'd0 : par_a;

    param_acc = !item.param_button_level && !bypass_flag && (effect_sel_next != 2'd0) &&
                !((chain_acc || effect_acc) ? locked_after : locked_now);
    if (param_acc) begin
      param_val_next = (par_b >= MAX_PARAM) ? 4'd0 : par_b + 4'd1;
    end else begin
      param_val_next = par_b;
    end
    show_a = param_acc || show_param_flag;

    bypass_acc = !item.bypass_button_level &&
                 !((chain_acc || effect_acc || param_acc) ? locked_after : locked_now);
    bypass_flag_next = bypass_flag ^ bypass_acc;

    any_acc = chain_acc || effect_acc || param_acc || bypass_acc;
    count_a = any_acc ? 16'd0 : lockout_count;
    lockout_count_next = (count_a == COUNT_MAX) ? count_a : count_a + 16'd1;
    show_param_flag_next = (lockout_count_next > lockout_ticks) ? 1'b0 : show_a;

    // Wrapping from the last position back to the first clears both tables.
    for (int i = 0; i < NUM_POS; i++) begin
      if (chain_acc && position == 2'd3) begin
        effect_table_next[i] = 2'd0;
        param_table_next[i]  = 4'd0;
      end else begin
        effect_table_next[i] = effect_table[i];
        param_table_next[i]  = param_table[i];
      end
      if (position_next == i[1:0]) begin
        effect_table_next[i] = effect_sel_next;
        param_table_next[i]  = param_val_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      lockout_count   <= 16'd0;
      position        <= 2'd0;
      effect_sel      <= 2'd0;
      param_val       <= 4'd0;
      bypass_flag     <= 1'b0;
      show_param_flag <= 1'b0;
      effect_table    <= '0;
      param_table     <= '0;
    end else if (advance) begin
      lockout_count   <= lockout_count_next;
      position        <= position_next;
      effect_sel      <= effect_sel_next;
      param_val       <= param_val_next;
      bypass_flag     <= bypass_flag_next;
      show_param_flag <= show_param_flag_next;
      effect_table    <= effect_table_next;
      param_table     <= param_table_next;
    end
  end

  always_comb begin
    disp.bypass     = bypass_flag_next;
    disp.show_param = show_a;
    disp.param      = param_val_next;
    disp.position   = position_next;
    disp.effect     = effect_sel_next;
    tables.bypass_on  = bypass_flag_next;
    tables.effect_tab = effect_table_next;
    tables.param_tab  = param_table_next;
  end

endmodule

@@ rtl/effect_chain_panel_controller.sv @@
// Top level of the effect chain panel controller.
// Input request register, panel state update, display encoder and result register.
// Depends on ecpc_pkg, ecpc_core and ecpc_glyph.
//
// Each request is one polling tick with four active-low button levels; each produces
// exactly one result with the seven-segment port word, the bypass flag and the
// per-position effect and parameter tables. One request is taken every clock cycle
// when the result side keeps up. A request's result is registered: the input register
// feeds the state update and display encoder directly, and the result register loads
// from them once the result side is free. A stalled result holds the input register,
// which then holds off new requests.
// The lockout length is written through cfg_we/cfg_wdata and resets to 7000 ticks.
module effect_chain_panel_controller
  import ecpc_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  in_t         in_item,
  output logic        out_valid,
  input  logic        out_ready,
  output out_t        out_item,
  input  logic        cfg_we,
  input  logic [15:0] cfg_wdata
);

  logic [15:0] lockout_ticks;
  logic        stage_valid;
  in_t         stage_item;
  logic        advance;
  disp_sel_t   disp;
  tables_t     tables;
  logic [15:0] port_word;

  assign advance  = stage_valid && (!out_valid || out_ready);
  assign in_ready = !stage_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      lockout_ticks <= LOCKOUT_RESET;
    end else if (cfg_we) begin
      lockout_ticks <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= 1'b0;
    end else if (in_ready) begin
      stage_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      stage_item <= in_item;
    end
  end

  ecpc_core u_core (
    .clk           (clk),
    .rst           (rst),
    .advance       (advance),
    .item          (stage_item),
    .lockout_ticks (lockout_ticks),
    .disp          (disp),
    .tables        (tables)
  );

  ecpc_glyph u_glyph (
    .disp      (disp),
    .port_word (port_word)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_item.display_port <= port_word;
      out_item.bypass_on    <= tables.bypass_on;
      out_item.effect_pos0  <= tables.effect_tab[0];
      out_item.effect_pos1  <= tables.effect_tab[1];
      out_item.effect_pos2  <= tables.effect_tab[2];
      out_item.effect_pos3  <= tables.effect_tab[3];
      out_item.param_pos0   <= tables.param_tab[0];
      out_item.param_pos1   <= tables.param_tab[1];
      out_item.param_pos2   <= tables.param_tab[2];
      out_item.param_pos3   <= tables.param_tab[3];
    end
  end

endmodule

@@ bench/testbench.sv @@
// Self-checking bench for effect_chain_panel_controller: random and directed button requests,
// a tick-level model of the panel state, and field-by-field checks of every result.
// Depends on ecpc_pkg and the RTL of effect_chain_panel_controller.
module testbench;
  import ecpc_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 100000;
  localparam logic [3:0] PRESS_NONE = 4'b0000;
  localparam logic [3:0] PRESS_CHAIN = 4'b1000;
  localparam logic [3:0] PRESS_EFFECT = 4'b0100;
  localparam logic [3:0] PRESS_PARAM = 4'b0010;
  localparam logic [3:0] PRESS_BYPASS = 4'b0001;
  localparam logic [3:0] PRESS_ALL = 4'b1111;
  localparam logic [6:0] DASH_SEG = 7'h40;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_ready;
  in_t         in_item = '1;
  logic        out_valid;
  logic        out_ready = 1'b0;
  out_t        out_item;
  logic        cfg_we = 1'b0;
  logic [15:0] cfg_wdata = 16'd0;

  // Panel state as the testbench sees it.
  logic [15:0] lock_len;
  logic [15:0] lock_cnt;
  logic [1:0]  chain_pos;
  logic [1:0]  effect_no;
  logic [3:0]  param_no;
  logic        bypassed;
  logic        showing_param;
  logic [1:0]  effect_at [4];
  logic [3:0]  param_at [4];

  in_t  ticks_pending [$];
  out_t results_due [$];

  int unsigned error_count = 0;
  int unsigned cycle_count = 0;
  int unsigned send_odds = 0;
  int unsigned recv_odds = 0;
  int unsigned send_gap = 0;
  int unsigned recv_gap = 0;

  effect_chain_panel_controller DUT (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_item  (out_item),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  always #4 clk = ~clk;

  function automatic logic [6:0] digit_seg(logic [3:0] d);
    case (d)
      4'd0: return 7'h3F;
      4'd1: return 7'h06;
      4'd2: return 7'h5B;
      4'd3: return 7'h4F;
      4'd4: return 7'h66;
      4'd5: return 7'h6D;
      4'd6: return 7'h7D;
      4'd7: return 7'h07;
      4'd8: return 7'h7F;
      default: return 7'h6F;
    endcase
  endfunction

  function automatic logic [6:0] effect_seg(logic [1:0] pos, logic [1:0] eff);
    case ({pos, eff})
      4'h0: return 7'h3F;
      4'h1: return 7'h76;
      4'h2: return 7'h6D;
      4'h3: return 7'h39;
      4'h4: return 7'h06;
      4'h5: return 7'h38;
      4'h6: return 7'h7C;
      4'h7: return 7'h76;
      4'h8: return 7'h5B;
      4'h9: return 7'h39;
      4'hA: return 7'h71;
      4'hB: return 7'h78;
      4'hC: return 7'h4F;
      4'hD: return 7'h5E;
      4'hE: return 7'h79;
      default: return 7'h50;
    endcase
  endfunction

  // The panel wiring moves the low segment bits around before the port is inverted.
  function automatic logic [15:0] port_of(logic [6:0] g);
    logic [6:0] s;
    s = {g[6], g[5], g[0], g[1], g[4], g[3], g[2]};
    return 16'hFFFF ^ ({9'd0, s} << 5);
  endfunction

  task automatic clear_panel();
    lock_len = LOCKOUT_RESET;
    lock_cnt = 16'd0;
    chain_pos = 2'd0;
    effect_no = 2'd0;
    param_no = 4'd0;
    bypassed = 1'b0;
    showing_param = 1'b0;
    for (int i = 0; i < 4; i++) begin
      effect_at[i] = 2'd0;
      param_at[i] = 4'd0;
    end
  endtask

  // One polling tick; the lockout is tested anew for each button in priority order.
  task automatic advance_panel(in_t t);
    logic [6:0] seg;
    out_t r;
    if (!t.chain_button_level && lock_cnt >= lock_len && !bypassed) begin
      effect_no = 2'd0;
      param_no = 4'd0;
      if (chain_pos == 2'd3) begin
        chain_pos = 2'd0;
        for (int i = 0; i < 4; i++) begin
          effect_at[i] = 2'd0;
          param_at[i] = 4'd0;
        end
      end else begin
        chain_pos = chain_pos + 2'd1;
      end
      lock_cnt = 16'd0;
    end
    if (!t.effect_button_level && lock_cnt >= lock_len && !bypassed) begin
      effect_no = effect_no + 2'd1;
      param_no = 4'd0;
      lock_cnt = 16'd0;
    end
    if (!t.param_button_level && lock_cnt >= lock_len && effect_no != 2'd0 && !bypassed) begin
      param_no = (param_no >= MAX_PARAM) ? 4'd0 : param_no + 4'd1;
      showing_param = 1'b1;
      lock_cnt = 16'd0;
    end
    if (!t.bypass_button_level && lock_cnt >= lock_len) begin
      bypassed = !bypassed;
      lock_cnt = 16'd0;
    end
    effect_at[chain_pos] = effect_no;
    param_at[chain_pos] = param_no;
    if (bypassed)
      seg = DASH_SEG;
    else if (showing_param)
      seg = digit_seg(param_no);
    else
      seg = effect_seg(chain_pos, effect_no);
    if (lock_cnt != COUNT_MAX)
      lock_cnt = lock_cnt + 16'd1;
    if (lock_cnt > lock_len)
      showing_param = 1'b0;
    r.display_port = port_of(seg);
    r.bypass_on = bypassed;
    r.effect_pos0 = effect_at[0];
    r.effect_pos1 = effect_at[1];
    r.effect_pos2 = effect_at[2];
    r.effect_pos3 = effect_at[3];
    r.param_pos0 = param_at[0];
    r.param_pos1 = param_at[1];
    r.param_pos2 = param_at[2];
    r.param_pos3 = param_at[3];
    results_due.push_back(r);
  endtask

  task automatic report_error(string msg);
    $display("ERROR at cycle %0d: %s", cycle_count, msg);
    error_count++;
  endtask

  task automatic check_field(string name, int unsigned got, int unsigned want);
    if (got != want)
      report_error($sformatf("%s is %0h, expected %0h", name, got, want));
  endtask

  task automatic take_result(out_t got);
    out_t want;
    if (results_due.size() == 0) begin
      report_error("result arrived with no request outstanding");
    end else begin
      want = results_due.pop_front();
      check_field("display_port", got.display_port, want.display_port);
      check_field("bypass_on", got.bypass_on, want.bypass_on);
      check_field("effect_pos0", got.effect_pos0, want.effect_pos0);
      check_field("effect_pos1", got.effect_pos1, want.effect_pos1);
      check_field("effect_pos2", got.effect_pos2, want.effect_pos2);
      check_field("effect_pos3", got.effect_pos3, want.effect_pos3);
      check_field("param_pos0", got.param_pos0, want.param_pos0);
      check_field("param_pos1", got.param_pos1, want.param_pos1);
      check_field("param_pos2", got.param_pos2, want.param_pos2);
      check_field("param_pos3", got.param_pos3, want.param_pos3);
    end
  endtask

  // Request side: one new request is loaded only when the previous one is taken.
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
      send_gap = 0;
    end else if (!in_valid || in_ready) begin
      if (in_valid)
        advance_panel(in_item);
      if (send_gap > 0) begin
        send_gap--;
        in_valid <= 1'b0;
      end else if (ticks_pending.size() == 0) begin
        in_valid <= 1'b0;
      end else if (send_odds != 0 && $urandom_range(send_odds - 1, 0) == 0) begin
        send_gap = $urandom_range(1, 8) - 1;
        in_valid <= 1'b0;
      end else begin
        in_item <= ticks_pending.pop_front();
        in_valid <= 1'b1;
      end
    end
  end

  // Result side.
  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
      recv_gap = 0;
    end else begin
      if (out_valid && out_ready)
        take_result(out_item);
      if (recv_gap > 0) begin
        recv_gap--;
        out_ready <= 1'b0;
      end else if (recv_odds != 0 && $urandom_range(recv_odds - 1, 0) == 0) begin
        recv_gap = $urandom_range(1, 8) - 1;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  function automatic in_t levels_of(logic [3:0] pressed);
    in_t t;
    t = ~pressed;
    return t;
  endfunction

  function automatic in_t noise_tick();
    logic [3:0] pressed;
    pressed[3] = ($urandom_range(3, 0) == 0);
    pressed[2] = ($urandom_range(2, 0) == 0);
    pressed[1] = ($urandom_range(1, 0) == 0);
    pressed[0] = ($urandom_range(9, 0) == 0);
    return levels_of(pressed);
  endfunction

  function automatic logic [3:0] menu_press();
    int unsigned pick;
    pick = $urandom_range(11, 0);
    if (pick < 2)
      return PRESS_CHAIN;
    else if (pick < 5)
      return PRESS_EFFECT;
    else if (pick < 10)
      return PRESS_PARAM;
    else if (pick == 10)
      return PRESS_BYPASS;
    return 4'($urandom_range(15, 0));
  endfunction

  // Mostly single presses spaced around the lockout length, with some noise in between.
  task automatic push_menu_walk(int unsigned n, int unsigned len);
    int unsigned pushed;
    int unsigned gap;
    pushed = 0;
    while (pushed < n) begin
      if ($urandom_range(3, 0) == 0) begin
        ticks_pending.push_back(noise_tick());
        pushed++;
      end else begin
        ticks_pending.push_back(levels_of(menu_press()));
        pushed++;
        gap = $urandom_range((len < 30) ? len + 1 : 30, 0);
        repeat (gap) ticks_pending.push_back(levels_of(PRESS_NONE));
        pushed += gap;
      end
    end
  endtask

  task automatic pick_idling();
    send_odds = ($urandom_range(3, 0) == 0) ? 0 : $urandom_range(12, 3);
    recv_odds = ($urandom_range(3, 0) == 0) ? 0 : $urandom_range(12, 3);
  endtask

  task automatic wait_drained();
    while (ticks_pending.size() != 0 || in_valid || results_due.size() != 0)
      @(posedge clk);
  endtask

  task automatic set_lockout(logic [15:0] value);
    wait_drained();
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    lock_len = value;
    pick_idling();
  endtask

  task automatic push_presses(logic [3:0] pressed, int unsigned n);
    repeat (n) ticks_pending.push_back(levels_of(pressed));
  endtask

  initial begin
    clear_panel();
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // Lockout from reset: presses are ignored during the first 7000 ticks.
    pick_idling();
    push_presses(PRESS_NONE, 1);
    push_presses(PRESS_ALL, 1);
    repeat (100) ticks_pending.push_back(noise_tick());

    // Shortest lockout: walk the menus one press per tick.
    set_lockout(16'd1);
    push_presses(PRESS_NONE, 1);
    push_presses(PRESS_EFFECT, 1);
    push_presses(PRESS_PARAM, 11);   // climbs to nine, wraps to zero, then one
    push_presses(PRESS_EFFECT, 3);   // effect number wraps back to none
    push_presses(PRESS_PARAM, 1);    // ignored with no effect chosen
    push_presses(PRESS_BYPASS, 1);
    push_presses(PRESS_CHAIN, 1);    // ignored while bypassed
    push_presses(PRESS_EFFECT, 1);
    push_presses(PRESS_BYPASS, 1);
    push_presses(PRESS_CHAIN, 1);
    push_presses(PRESS_EFFECT, 1);
    push_presses(PRESS_PARAM, 1);
    push_presses(PRESS_CHAIN, 3);    // last step wraps the position and clears the tables
    push_presses(PRESS_ALL, 1);

    // No lockout at all: every button of a tick can take effect together.
    set_lockout(16'd0);
    push_menu_walk(200, 0);
    set_lockout(16'd1);
    push_menu_walk(300, 1);
    set_lockout(16'd2);
    push_menu_walk(200, 2);
    set_lockout(16'd3);
    push_menu_walk(200, 3);
    set_lockout(16'd5);
    push_menu_walk(200, 5);
    set_lockout(16'd17);
    push_menu_walk(200, 17);
    set_lockout(16'($urandom_range(40, 1)));
    push_menu_walk(200, lock_len);

    // Near-maximum lockout: presses stay ignored.
    set_lockout(16'd65534);
    repeat (20) ticks_pending.push_back(noise_tick());

    set_lockout(16'd1);
    send_odds = 0;
    recv_odds = 0;
    push_menu_walk(200, 1);

    wait_drained();
    repeat (12) @(posedge clk);
    if (results_due.size() != 0)
      report_error($sformatf("%0d results never arrived", results_due.size()));
    if (error_count == 0)
      $display("Testbench completed without errors");
    else
      $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
